>>> rtl/odo_pkg.sv
// Shared types, codes and constants of the wheel odometry integrator.
`default_nettype none
package odo_pkg;

  typedef enum logic [1:0] {
    OP_LEFT_EDGE  = 2'd0,
    OP_RIGHT_EDGE = 2'd1,
    OP_TICK       = 2'd2,
    OP_ZERO_POSE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t  operation;
    logic chan_a;
    logic chan_b;
  } item_t;

  typedef struct packed {
    logic signed [63:0] pos_x;
    logic signed [63:0] pos_y;
    logic [31:0]        bearing;
  } result_t;

  localparam int DELTA_BITS = 32;

  // Work handed from the front end to the back end.
  typedef struct packed {
    logic                         zero_pose;
    logic signed [DELTA_BITS-1:0] delta_left;
    logic signed [DELTA_BITS-1:0] delta_right;
  } cmd_t;

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT_STEP  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RIGHT_STEP = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TURN_GAIN  = 2'd2;

  localparam logic [31:0] LEFT_STEP_RESET  = 32'd893174;
  localparam logic [31:0] RIGHT_STEP_RESET = 32'd898262;
  localparam logic [31:0] TURN_GAIN_RESET  = 32'd3806043605;

  localparam int ROT_BITS = 34;
  localparam logic signed [ROT_BITS-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL_L, ST_MUL_R, ST_CAP_R, ST_SUM, ST_HEAD_LO, ST_HEAD_HI,
    ST_TURN, ST_SETUP, ST_ROTATE, ST_FIX, ST_X_LO, ST_X_HI, ST_X_ADD,
    ST_Y_HI, ST_Y_ADD, ST_OUT
  } state_t;

  // Arctangent of 2^-i in binary angle units.
  function automatic logic [31:0] atan_angle(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      5'd31: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

>>> rtl/odo_queue.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none
module odo_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire odo_pkg::cmd_t wr_cmd,
  output logic               full,
  input  wire logic          rd,
  output logic               valid,
  output odo_pkg::cmd_t      rd_cmd
);
  import odo_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full   = (count == 2'd2);
  assign valid  = (count != 2'd0);
  assign rd_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(wr) - 2'(rd);
    end
  end

endmodule
`default_nettype wire

>>> rtl/odo_front.sv
// Front end: takes input transactions, steps the encoder counts and queues ticks and pose resets.
`default_nettype none
module odo_front #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire odo_pkg::item_t item,
  output logic                full,
  input  wire logic           q_full,
  output logic                q_wr,
  output odo_pkg::cmd_t       q_cmd
);
  import odo_pkg::*;

  logic [COUNT_BITS-1:0] left_count;
  logic [COUNT_BITS-1:0] right_count;
  logic [COUNT_BITS-1:0] left_seen;
  logic [COUNT_BITS-1:0] right_seen;
  logic                  accept;
  logic [COUNT_BITS-1:0] dl;
  logic [COUNT_BITS-1:0] dr;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign dl     = left_count - left_seen;
  assign dr     = right_count - right_seen;

  always_comb begin
    q_wr                = accept && (item.operation == OP_TICK || item.operation == OP_ZERO_POSE);
    q_cmd.zero_pose     = (item.operation == OP_ZERO_POSE);
    q_cmd.delta_left    = DELTA_BITS'($signed(dl));
    q_cmd.delta_right   = DELTA_BITS'($signed(dr));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= '0;
      right_count <= '0;
      left_seen   <= '0;
      right_seen  <= '0;
    end else if (accept) begin
      unique case (item.operation)
        OP_LEFT_EDGE: begin
          if (item.chan_a == item.chan_b) begin
            left_count <= left_count + 1'b1;
          end else begin
            left_count <= left_count - 1'b1;
          end
        end
        OP_RIGHT_EDGE: begin
          if (item.chan_a != item.chan_b) begin
            right_count <= right_count + 1'b1;
          end else begin
            right_count <= right_count - 1'b1;
          end
        end
        OP_TICK: begin
          left_seen  <= left_count;
          right_seen <= right_count;
        end
        OP_ZERO_POSE: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/odo_back.sv
// Back end: sequencer that scales wheel travel, turns the heading and moves or zeroes the pose.
`default_nettype none
module odo_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire odo_pkg::cmd_t    q_cmd,
  output logic                  q_rd,
  input  wire logic [31:0]      left_step_length,
  input  wire logic [31:0]      right_step_length,
  input  wire logic [31:0]      turn_gain,
  output logic                  empty,
  input  wire logic             pop,
  output odo_pkg::result_t      result
);
  import odo_pkg::*;

  localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [SW-1:0] LAST_STEP = SW'(CORDIC_STEPS - 1);

  state_t state, state_next;

  cmd_t                       cmd;
  logic [31:0]                mul_a, mul_b;
  logic [63:0]                prod;
  logic signed [63:0]         dsl, dsr, ds, diff;
  logic [63:0]                ha;
  logic [31:0]                bearing_acc;
  logic signed [63:0]         x_acc, y_acc;
  logic                       flip;
  logic signed [ROT_BITS-1:0] cx, cy, cz;
  logic [SW-1:0]              step;
  logic [63:0]                ds_mag;
  logic                       ds_neg;
  logic [31:0]                sn_mag, cs_mag;
  logic                       sn_neg, cs_neg;
  logic [63:0]                lo_p;
  logic                       out_valid;
  logic                       out_load;
  logic [31:0]                left_mag, right_mag;
  logic signed [64:0]         ds_sum;
  logic [31:0]                rot_angle;
  logic [31:0]                atan_cur;
  logic signed [ROT_BITS-1:0] sn_full, cs_full;
  logic [63:0]                term;

  assign left_mag  = cmd.delta_left[DELTA_BITS-1] ? 32'(-cmd.delta_left) : 32'(cmd.delta_left);
  assign right_mag = cmd.delta_right[DELTA_BITS-1] ? 32'(-cmd.delta_right) : 32'(cmd.delta_right);
  assign ds_sum    = 65'(dsl) + 65'(dsr);
  assign rot_angle = flip_angle(bearing_acc);
  assign atan_cur  = atan_angle(5'(step));
  assign sn_full   = flip ? -cy : cy;
  assign cs_full   = flip ? -cx : cx;
  assign term      = (prod << 2) + (lo_p >> 30);
  assign empty     = !out_valid;
  assign out_load  = (state == ST_OUT) && (!out_valid || pop);

  // Angles outside the right half plane are turned by half a turn first.
  function automatic logic [31:0] flip_angle(input logic [31:0] ang);
    logic [31:0] q;
    q = ang + 32'h4000_0000;
    return q[31] ? ang + 32'h8000_0000 : ang;
  endfunction

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && !q_cmd.zero_pose) begin
          state_next = ST_MUL_L;
        end
      end
      ST_MUL_L:   state_next = ST_MUL_R;
      ST_MUL_R:   state_next = ST_CAP_R;
      ST_CAP_R:   state_next = ST_SUM;
      ST_SUM:     state_next = ST_HEAD_LO;
      ST_HEAD_LO: state_next = ST_HEAD_HI;
      ST_HEAD_HI: state_next = ST_TURN;
      ST_TURN:    state_next = ST_SETUP;
      ST_SETUP:   state_next = ST_ROTATE;
      ST_ROTATE: begin
        if (step == LAST_STEP) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX:     state_next = ST_X_LO;
      ST_X_LO:    state_next = ST_X_HI;
      ST_X_HI:    state_next = ST_X_ADD;
      ST_X_ADD:   state_next = ST_Y_HI;
      ST_Y_HI:    state_next = ST_Y_ADD;
      ST_Y_ADD:   state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || pop) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // Operand selection for the shared 32 x 32 multiplier.
  always_comb begin
    q_rd  = (state == ST_IDLE) && q_valid;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MUL_L: begin
        mul_a = left_mag;
        mul_b = left_step_length;
      end
      ST_MUL_R: begin
        mul_a = right_mag;
        mul_b = right_step_length;
      end
      ST_HEAD_LO: begin
        mul_a = diff[31:0];
        mul_b = turn_gain;
      end
      ST_HEAD_HI: begin
        mul_a = diff[63:32];
        mul_b = turn_gain;
      end
      ST_X_LO: begin
        mul_a = ds_mag[31:0];
        mul_b = sn_mag;
      end
      ST_X_HI: begin
        mul_a = ds_mag[63:32];
        mul_b = sn_mag;
      end
      ST_X_ADD: begin
        mul_a = ds_mag[31:0];
        mul_b = cs_mag;
      end
      ST_Y_HI: begin
        mul_a = ds_mag[63:32];
        mul_b = cs_mag;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      bearing_acc <= '0;
      x_acc       <= '0;
      y_acc       <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_rd && q_cmd.zero_pose) begin
        bearing_acc <= '0;
        x_acc       <= '0;
        y_acc       <= '0;
      end
      if (state == ST_TURN) begin
        bearing_acc <= bearing_acc + prod[31:0] + ha[63:32];
      end
      if (state == ST_X_ADD) begin
        x_acc <= (ds_neg ^ sn_neg) ? x_acc - $signed(term) : x_acc + $signed(term);
      end
      if (state == ST_Y_ADD) begin
        y_acc <= (ds_neg ^ cs_neg) ? y_acc - $signed(term) : y_acc + $signed(term);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_rd) begin
          cmd <= q_cmd;
        end
      end
      ST_MUL_R: begin
        dsl <= cmd.delta_left[DELTA_BITS-1] ? -$signed(prod) : $signed(prod);
      end
      ST_CAP_R: begin
        dsr <= cmd.delta_right[DELTA_BITS-1] ? -$signed(prod) : $signed(prod);
      end
      ST_SUM: begin
        ds   <= ds_sum[64:1];
        diff <= dsr - dsl;
      end
      ST_HEAD_HI: begin
        ha <= prod;
      end
      ST_SETUP: begin
        flip <= ((bearing_acc + 32'h4000_0000) >> 31) != 32'd0;
        cx   <= CORDIC_GAIN;
        cy   <= '0;
        cz   <= ROT_BITS'($signed(rot_angle));
        step <= '0;
      end
      ST_ROTATE: begin
        if (!cz[ROT_BITS-1]) begin
          cx <= cx - (cy >>> step);
          cy <= cy + (cx >>> step);
          cz <= cz - $signed({2'b00, atan_cur});
        end else begin
          cx <= cx + (cy >>> step);
          cy <= cy - (cx >>> step);
          cz <= cz + $signed({2'b00, atan_cur});
        end
        step <= step + 1'b1;
      end
      ST_FIX: begin
        ds_neg <= ds[63];
        ds_mag <= ds[63] ? 64'(-ds) : 64'(ds);
        sn_neg <= sn_full[ROT_BITS-1];
        cs_neg <= cs_full[ROT_BITS-1];
        sn_mag <= sn_full[ROT_BITS-1] ? 32'(-sn_full) : 32'(sn_full);
        cs_mag <= cs_full[ROT_BITS-1] ? 32'(-cs_full) : 32'(cs_full);
      end
      ST_X_HI: begin
        lo_p <= prod;
      end
      ST_Y_HI: begin
        lo_p <= prod;
      end
      ST_OUT: begin
        if (out_load) begin
          result.pos_x   <= x_acc;
          result.pos_y   <= y_acc;
          result.bearing <= bearing_acc;
        end
      end
      default: begin
      end
    endcase
  end

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> (state == ST_IDLE))
    else $error("command taken while the sequencer is busy");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROTATE) |-> (step <= LAST_STEP))
    else $error("rotation step out of range");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("loaded result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |-> !out_load)
    else $error("waiting result overwritten");

endmodule
`default_nettype wire

>>> rtl/wheel_odometry_integrator.sv
// Top level of the differential-drive wheel odometry integrator.
`default_nettype none
// Encoder edge transactions step the wheel counts in the cycle they are taken and
// produce no result. A tick transaction snapshots the count changes into a
// two-entry queue; the back end then works on it with eight passes through one
// shared 32 x 32 multiplier and the iterative CORDIC rotation, and the result
// waits in an output register until popped. A reset pose transaction passes the
// same queue and clears the pose as the back end takes it.
// Edge transactions keep flowing while the back end works, until the queue fills.
// Configuration writes take effect at once and belong in idle periods.
module wheel_odometry_integrator #(
  parameter int CORDIC_STEPS = 16,
  parameter int COUNT_BITS   = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   push,
  input  wire odo_pkg::item_t                         item,
  output logic                                        full,
  output logic                                        empty,
  input  wire logic                                   pop,
  output odo_pkg::result_t                            result,
  input  wire logic                                   wr_en,
  input  wire logic [odo_pkg::CFG_INDEX_BITS-1:0]     wr_index,
  input  wire logic [31:0]                            wr_data
);
  import odo_pkg::*;

  logic [31:0] left_step_length;
  logic [31:0] right_step_length;
  logic [31:0] turn_gain;
  logic        q_wr, q_full, q_rd, q_valid;
  cmd_t        q_in, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_step_length  <= LEFT_STEP_RESET;
      right_step_length <= RIGHT_STEP_RESET;
      turn_gain         <= TURN_GAIN_RESET;
    end else if (wr_en) begin
      priority case (wr_index)
        REG_LEFT_STEP:  left_step_length  <= wr_data;
        REG_RIGHT_STEP: right_step_length <= wr_data;
        REG_TURN_GAIN:  turn_gain         <= wr_data;
        default: begin
        end
      endcase
    end
  end

  odo_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_cmd  (q_in)
  );

  odo_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wr_cmd (q_in),
    .full   (q_full),
    .rd     (q_rd),
    .valid  (q_valid),
    .rd_cmd (q_out)
  );

  odo_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_cmd             (q_out),
    .q_rd              (q_rd),
    .left_step_length  (left_step_length),
    .right_step_length (right_step_length),
    .turn_gain         (turn_gain),
    .empty             (empty),
    .pop               (pop),
    .result            (result)
  );

endmodule
`default_nettype wire
